@@ rtl/gti_pkg.sv @@
// ----------------------------------------------------------------------------
// gti_pkg
// Shared types and constants of the trilinear grid interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package gti_pkg;

   localparam int MAX_CELLS = 32768;
   localparam int CHANNELS  = 8;

   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int CH_W    = 3;
   localparam int SIZE_W  = 7;
   localparam int SXY_W   = 2 * SIZE_W;
   localparam int DIFF_W  = DATA_W + 1;
   localparam int IDX_W   = 32;
   localparam int CIDX_W  = 21;
   localparam int CELL_AW = $clog2(MAX_CELLS);
   localparam int MEM_AW  = $clog2(MAX_CELLS * CHANNELS);
   localparam int MEM_DEPTH = MAX_CELLS * CHANNELS;
   localparam int AXES    = 3;
   localparam int CORNERS = 8;
   localparam int CNT_W   = 3;

   localparam int PROD_W = DIFF_W + FRAC_W + 1;
   localparam int SUM_W  = PROD_W + 1;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_ORIGIN_Z    = 3'd2,
      CSR_INV_SPACING = 3'd3,
      CSR_SIZE_X      = 3'd4,
      CSR_SIZE_Y      = 3'd5,
      CSR_SIZE_Z      = 3'd6,
      CSR_FAR_VALUE   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_BASE,
      ST_READ,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] data;
   } beat_type;

endpackage

`default_nettype wire

@@ rtl/gti_lerp.sv @@
// ----------------------------------------------------------------------------
// gti_lerp
// One blend stage: pairs consecutive beats and returns their linear blend,
// rounded half up to Q16.16. Product and output are both registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gti_lerp
   import gti_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire beat_type          in_beat,
   input  wire logic [FRAC_W-1:0] frac,
   output beat_type              out_beat
);

   logic                     half_ff;
   logic signed [DATA_W-1:0] held_ff;
   logic signed [DATA_W-1:0] base_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_valid_ff;
   logic                     out_valid_ff;
   logic [DATA_W-1:0]        out_data_ff;

   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [SUM_W-1:0]  sum;

   always_comb begin
      diff = $signed({in_beat.data[DATA_W-1], in_beat.data}) - $signed({held_ff[DATA_W-1], held_ff});
      prod = PROD_W'(diff * $signed({1'b0, frac}));
      sum  = $signed({{(SUM_W-DATA_W-FRAC_W){base_ff[DATA_W-1]}}, base_ff, {FRAC_W{1'b0}}})
           + $signed({prod_ff[PROD_W-1], prod_ff})
           + $signed(SUM_W'(1) <<< (FRAC_W - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff       <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (in_beat.valid) begin
            half_ff <= ~half_ff;
         end
         prod_valid_ff <= in_beat.valid & half_ff;
         out_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_beat.valid && !half_ff) begin
         held_ff <= $signed(in_beat.data);
      end
      if (in_beat.valid && half_ff) begin
         base_ff <= held_ff;
         prod_ff <= prod;
      end
      if (prod_valid_ff) begin
         out_data_ff <= sum[DATA_W+FRAC_W-1:FRAC_W];
      end
   end

   assign out_beat.valid = out_valid_ff;
   assign out_beat.data  = out_data_ff;

endmodule

`default_nettype wire

@@ rtl/grid_trilinear_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// grid_trilinear_interpolator_core
// Eight-channel 3D field store with trilinear point queries in Q16.16.
// ----------------------------------------------------------------------------
// Write beat: busy stays low; a write may follow every cycle.
// Query outside the grid: busy through the multiply and base states; the
// strobe is registered from the base state. Query inside: busy until the
// blend result is out, after three axis multiplies on one multiplier, eight
// corner reads from the single-port grid memory and the three blend stages.
// Reset clears control and loads configuration defaults; grid contents stay undefined.
`default_nettype none

module grid_trilinear_interpolator_core
   import gti_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_action,
   input  wire logic [CH_W-1:0]   req_channel,
   input  wire logic [14:0]       req_cell_index,
   input  wire logic [DATA_W-1:0] req_cell_value,
   input  wire logic [DATA_W-1:0] req_query_x,
   input  wire logic [DATA_W-1:0] req_query_y,
   input  wire logic [DATA_W-1:0] req_query_z,
   output logic                   rsp_strobe,
   output logic [DATA_W-1:0]      rsp_value,
   output logic                   rsp_outside,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_index,
   input  wire logic [DATA_W-1:0] csr_write_data
);

   // configuration
   logic [DATA_W-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [DATA_W-1:0] inv_spacing_ff, far_value_ff;
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;

   // control
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             accept, mem_we, mem_rd, resp_far, any_out;

   // query datapath
   logic [CH_W-1:0]   ch_ff;
   logic [DIFF_W-1:0] diff_ff [AXES];
   logic [IDX_W-1:0]  idx_ff  [AXES];
   logic [FRAC_W-1:0] frac_ff [AXES];
   logic [SXY_W-1:0]  sxy_ff;
   logic [CIDX_W-1:0] base_ff;
   logic [DIFF_W-1:0] mul_d;
   logic [DATA_W-1:0] mul_mag;
   logic [2*DATA_W-1:0] mul_prod;
   logic [CIDX_W-1:0] base_in, corner_idx;
   logic              corner_ok, ch_ok;
   logic              out_x, out_y, out_z;

   // memory
   logic [DATA_W-1:0] grid_mem [MEM_DEPTH];
   logic [MEM_AW-1:0] mem_addr;
   logic [DATA_W-1:0] mem_q_ff;
   logic              rd_pend_ff, rd_ok_ff;

   // blend
   beat_type x_beat, y_beat, z_beat, w_beat;

   // response
   logic              rsp_strobe_ff, rsp_outside_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   function automatic logic axis_outside(input logic [DIFF_W-1:0] d,
                                         input logic inv_zero,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [SIZE_W-1:0] n);
      logic small_n;
      small_n = (n < SIZE_W'(2));
      return (d[DIFF_W-1] && !inv_zero) || small_n
             || (idx >= (IDX_W'(n) - IDX_W'(1)));
   endfunction

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         origin_z_ff    <= '0;
         inv_spacing_ff <= DATA_W'(65536);
         size_x_ff      <= SIZE_W'(32);
         size_y_ff      <= SIZE_W'(32);
         size_z_ff      <= SIZE_W'(32);
         far_value_ff   <= DATA_W'(32'h7FFF_FFFF);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:    origin_x_ff    <= csr_write_data;
            CSR_ORIGIN_Y:    origin_y_ff    <= csr_write_data;
            CSR_ORIGIN_Z:    origin_z_ff    <= csr_write_data;
            CSR_INV_SPACING: inv_spacing_ff <= csr_write_data;
            CSR_SIZE_X:      size_x_ff      <= csr_write_data[SIZE_W-1:0];
            CSR_SIZE_Y:      size_y_ff      <= csr_write_data[SIZE_W-1:0];
            CSR_SIZE_Z:      size_z_ff      <= csr_write_data[SIZE_W-1:0];
            CSR_FAR_VALUE:   far_value_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      busy     = 1'b1;
      mem_rd   = 1'b0;
      resp_far = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start && req_action == ACT_QUERY) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff == CNT_W'(AXES - 1)) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            if (any_out) begin
               resp_far = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mem_rd = 1'b1;
            if (cnt_ff == CNT_W'(CORNERS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (z_beat.valid) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (state_in != state_ff) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign accept = start && !busy;
   assign ch_ok  = ({1'b0, ch_ff} < (CH_W+1)'(CHANNELS));
   assign mem_we = accept && req_action == ACT_WRITE
                   && ({1'b0, req_channel} < (CH_W+1)'(CHANNELS))
                   && (CELL_AW'(req_cell_index) < CELL_AW'(MAX_CELLS - 1)
                       || CELL_AW'(req_cell_index) == CELL_AW'(MAX_CELLS - 1));

   // axis mapping: one multiplier shared over the three axes
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    mul_d = diff_ff[0];
         2'd1:    mul_d = diff_ff[1];
         default: mul_d = diff_ff[2];
      endcase
      mul_mag  = mul_d[DIFF_W-1] ? '0 : mul_d[DATA_W-1:0];
      mul_prod = mul_mag * inv_spacing_ff;
   end

   always_comb begin
      out_x   = axis_outside(diff_ff[0], inv_spacing_ff == '0, idx_ff[0], size_x_ff);
      out_y   = axis_outside(diff_ff[1], inv_spacing_ff == '0, idx_ff[1], size_y_ff);
      out_z   = axis_outside(diff_ff[2], inv_spacing_ff == '0, idx_ff[2], size_z_ff);
      any_out = out_x || out_y || out_z;
      base_in = CIDX_W'(idx_ff[0][SIZE_W-1:0])
              + CIDX_W'(size_x_ff * idx_ff[1][SIZE_W-1:0])
              + CIDX_W'(sxy_ff * idx_ff[2][SIZE_W-1:0]);
      corner_idx = base_ff
                 + (cnt_ff[0] ? CIDX_W'(1) : '0)
                 + (cnt_ff[1] ? CIDX_W'(size_x_ff) : '0)
                 + (cnt_ff[2] ? CIDX_W'(sxy_ff) : '0);
      corner_ok = ch_ok && (corner_idx < CIDX_W'(MAX_CELLS));
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff      <= req_channel;
         diff_ff[0] <= {req_query_x[DATA_W-1], req_query_x}
                     - {origin_x_ff[DATA_W-1], origin_x_ff};
         diff_ff[1] <= {req_query_y[DATA_W-1], req_query_y}
                     - {origin_y_ff[DATA_W-1], origin_y_ff};
         diff_ff[2] <= {req_query_z[DATA_W-1], req_query_z}
                     - {origin_z_ff[DATA_W-1], origin_z_ff};
      end
      if (state_ff == ST_MUL) begin
         idx_ff[cnt_ff[1:0]]  <= mul_prod[2*DATA_W-1:DATA_W];
         frac_ff[cnt_ff[1:0]] <= mul_prod[DATA_W-1:DATA_W-FRAC_W];
         sxy_ff               <= size_x_ff * size_y_ff;
      end
      if (state_ff == ST_BASE) begin
         base_ff <= base_in;
      end
   end

   // grid memory: single port, writes when idle, corner reads while busy
   assign mem_addr = mem_rd ? {ch_ff, corner_idx[CELL_AW-1:0]}
                            : {req_channel, req_cell_index[CELL_AW-1:0]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_addr] <= req_cell_value;
      end
      if (mem_rd) begin
         mem_q_ff <= grid_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= mem_rd;
      end
      rd_ok_ff <= corner_ok;
   end

   assign x_beat.valid = rd_pend_ff;
   assign x_beat.data  = rd_ok_ff ? mem_q_ff : '0;

   gti_lerp u_lerp_x (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (x_beat),
      .frac     (frac_ff[0]),
      .out_beat (y_beat)
   );

   gti_lerp u_lerp_y (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (y_beat),
      .frac     (frac_ff[1]),
      .out_beat (w_beat)
   );

   gti_lerp u_lerp_z (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (w_beat),
      .frac     (frac_ff[2]),
      .out_beat (z_beat)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= resp_far || (state_ff == ST_DRAIN && z_beat.valid);
      end
      if (resp_far) begin
         rsp_value_ff   <= (ch_ff <= CH_W'(1)) ? far_value_ff : '0;
         rsp_outside_ff <= 1'b1;
      end else if (z_beat.valid) begin
         rsp_value_ff   <= z_beat.data;
         rsp_outside_ff <= 1'b0;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_outside = rsp_outside_ff;

   // checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a query in flight");

   a_blend_in_drain: assert property (@(posedge clock) disable iff (reset)
      z_beat.valid |-> state_ff == ST_DRAIN)
      else $error("blend result outside drain state");

   a_no_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      mem_rd |-> !mem_we)
      else $error("grid memory read and write in one cycle");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trilinear grid interpolator core.
// Loads field cells and issues point queries over several grid settings:
// default, minimum and maximum sizes, extreme origins, zero and maximum
// inverse spacing. A predictor tracks the field store and blends every
// query in Q16.16. A query only lands on corners that have already been
// written, or on corners that lie beyond the store. Each result beat is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gti_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 25;
   localparam int PHASE_ITEMS = 175;

   typedef longint unsigned u64_type;

   typedef struct packed {
      action_type          act;
      logic [CH_W-1:0]     ch;
      logic [14:0]         cell_no;
      logic [DATA_W-1:0]   val;
      logic [DATA_W-1:0]   qx;
      logic [DATA_W-1:0]   qy;
      logic [DATA_W-1:0]   qz;
      logic                settle;
   } grid_beat_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              outside;
   } blend_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_action = 1'b0;
   logic [CH_W-1:0]     req_channel = '0;
   logic [14:0]         req_cell_index = '0;
   logic [DATA_W-1:0]   req_cell_value = '0;
   logic [DATA_W-1:0]   req_query_x = '0;
   logic [DATA_W-1:0]   req_query_y = '0;
   logic [DATA_W-1:0]   req_query_z = '0;
   logic                rsp_strobe;
   logic [DATA_W-1:0]   rsp_value;
   logic                rsp_outside;
   logic                csr_write_enable = 1'b0;
   csr_index_type       csr_index = CSR_ORIGIN_X;
   logic [DATA_W-1:0]   csr_write_data = '0;

   logic [DATA_W-1:0]   cfg_origin [AXES];
   logic [DATA_W-1:0]   cfg_inv;
   logic [SIZE_W-1:0]   cfg_size [AXES];
   logic [DATA_W-1:0]   cfg_far;

   logic [DATA_W-1:0]   field_mem [MEM_DEPTH];
   bit                  loaded [MEM_DEPTH];

   grid_beat_type       beat_queue [$];
   blend_type           blend_expect [$];

   logic                accepted_now = 1'b0;
   bit                  settle_next = 1'b0;
   int                  gap_left = 0;
   int                  burst_left = 0;
   int                  n_pushed = 0;
   int                  n_writes = 0;
   int                  n_queries = 0;
   int                  n_outside = 0;
   int                  n_errors = 0;
   int                  n_phases = 1;
   int unsigned         cycle_count = 0;

   grid_trilinear_interpolator_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_channel      (req_channel),
      .req_cell_index   (req_cell_index),
      .req_cell_value   (req_cell_value),
      .req_query_x      (req_query_x),
      .req_query_y      (req_query_y),
      .req_query_z      (req_query_z),
      .rsp_strobe       (rsp_strobe),
      .rsp_value        (rsp_value),
      .rsp_outside      (rsp_outside),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic bit map_axis(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] o,
                                   input logic [DATA_W-1:0] inv, input logic [SIZE_W-1:0] n,
                                   output logic [IDX_W-1:0] idx, output logic [FRAC_W-1:0] frac);
      longint  d;
      u64_type mag;
      u64_type p;
      idx = '0;
      frac = '0;
      d = longint'($signed(q)) - longint'($signed(o));
      if (d < 0) begin
         mag = -d;
         p = mag * {32'h0, inv};
         if (p != 0) return 1'b0;
      end else begin
         mag = d;
         p = mag * {32'h0, inv};
         idx = p[63:32];
         frac = p[31:16];
      end
      if (n < 2 || u64_type'(idx) >= u64_type'(n) - 1) return 1'b0;
      return 1'b1;
   endfunction

   function automatic u64_type corner_offset(input int c);
      u64_type sx;
      u64_type r;
      sx = u64_type'(cfg_size[0]);
      r = 0;
      if (c & 1) r += 1;
      if (c & 2) r += sx;
      if (c & 4) r += sx * u64_type'(cfg_size[1]);
      return r;
   endfunction

   function automatic bit locate_cell(input grid_beat_type b, output u64_type base,
                                      output logic [FRAC_W-1:0] fx, output logic [FRAC_W-1:0] fy,
                                      output logic [FRAC_W-1:0] fz);
      logic [IDX_W-1:0] ix, iy, iz;
      bit      inx, iny, inz;
      u64_type sx, sxy;
      inx = map_axis(b.qx, cfg_origin[0], cfg_inv, cfg_size[0], ix, fx);
      iny = map_axis(b.qy, cfg_origin[1], cfg_inv, cfg_size[1], iy, fy);
      inz = map_axis(b.qz, cfg_origin[2], cfg_inv, cfg_size[2], iz, fz);
      sx = u64_type'(cfg_size[0]);
      sxy = sx * u64_type'(cfg_size[1]);
      base = u64_type'(ix) + sx * u64_type'(iy) + sxy * u64_type'(iz);
      return inx && iny && inz;
   endfunction

   function automatic longint lerp_q16(input longint a, input longint b,
                                       input logic [FRAC_W-1:0] f);
      longint w;
      longint s;
      w = longint'(f);
      s = a * (65536 - w) + b * w + 32768;
      return s >>> 16;
   endfunction

   function automatic blend_type predict_blend(input grid_beat_type b);
      u64_type base, idx;
      logic [FRAC_W-1:0] fx, fy, fz;
      longint e [CORNERS];
      longint r;
      blend_type res;
      if (!locate_cell(b, base, fx, fy, fz)) begin
         res.value = (b.ch <= 1) ? cfg_far : '0;
         res.outside = 1'b1;
         return res;
      end
      for (int c = 0; c < CORNERS; c++) begin
         idx = base + corner_offset(c);
         if (idx < MAX_CELLS)
            e[c] = longint'($signed(field_mem[int'(b.ch) * MAX_CELLS + int'(idx)]));
         else
            e[c] = 0;
      end
      for (int c = 0; c < 4; c++)
         e[c] = lerp_q16(e[2*c], e[2*c+1], fx);
      e[0] = lerp_q16(e[0], e[1], fy);
      e[1] = lerp_q16(e[2], e[3], fy);
      r = lerp_q16(e[0], e[1], fz);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.value = r[31:0];
      res.outside = 1'b0;
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] axis_point(input logic [DATA_W-1:0] o,
                                                   input logic [DATA_W-1:0] inv,
                                                   input logic [SIZE_W-1:0] n);
      u64_type span, d;
      if (n < 2 || $urandom_range(0, 15) == 0) return pick_word();
      if (inv == 0) begin
         span = 64'hFFFF_FFFF;
      end else begin
         span = ((u64_type'(n) - 1) << 32) / {32'h0, inv};
         if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      end
      case ($urandom_range(0, 15))
         0: d = span;
         1: d = 0;
         default: d = {$urandom, $urandom} % (span + 1);
      endcase
      return o + d[31:0];
   endfunction

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_beat(input grid_beat_type b);
      b.settle = settle_next;
      settle_next = 1'b0;
      beat_queue.push_back(b);
      n_pushed++;
   endtask

   task automatic push_write(input logic [CH_W-1:0] ch, input logic [14:0] cell_no,
                             input logic [DATA_W-1:0] val);
      grid_beat_type b;
      b.act = ACT_WRITE;
      b.ch = ch;
      b.cell_no = cell_no;
      b.val = val;
      b.qx = $urandom;
      b.qy = $urandom;
      b.qz = $urandom;
      b.settle = 1'b0;
      loaded[int'(ch) * MAX_CELLS + int'(cell_no)] = 1'b1;
      push_beat(b);
   endtask

   task automatic push_query(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] qx,
                             input logic [DATA_W-1:0] qy, input logic [DATA_W-1:0] qz);
      grid_beat_type b;
      u64_type base, idx;
      logic [FRAC_W-1:0] fx, fy, fz;
      b.act = ACT_QUERY;
      b.ch = ch;
      b.cell_no = 15'($urandom);
      b.val = $urandom;
      b.qx = qx;
      b.qy = qy;
      b.qz = qz;
      b.settle = 1'b0;
      if (locate_cell(b, base, fx, fy, fz)) begin
         for (int c = 0; c < CORNERS; c++) begin
            idx = base + corner_offset(c);
            if (idx < MAX_CELLS) begin
               if (!loaded[int'(ch) * MAX_CELLS + int'(idx)] || $urandom_range(0, 9) == 0)
                  push_write(ch, idx[14:0], pick_word());
            end
         end
      end
      push_beat(b);
   endtask

   task automatic wait_idle();
      while (beat_queue.size() != 0 || start || blend_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [DATA_W-1:0] d);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= d;
      case (idx)
         CSR_ORIGIN_X:    cfg_origin[0] = d;
         CSR_ORIGIN_Y:    cfg_origin[1] = d;
         CSR_ORIGIN_Z:    cfg_origin[2] = d;
         CSR_INV_SPACING: cfg_inv = d;
         CSR_SIZE_X:      cfg_size[0] = d[SIZE_W-1:0];
         CSR_SIZE_Y:      cfg_size[1] = d[SIZE_W-1:0];
         CSR_SIZE_Z:      cfg_size[2] = d[SIZE_W-1:0];
         CSR_FAR_VALUE:   cfg_far = d;
         default: ;
      endcase
   endtask

   function automatic logic [DATA_W-1:0] size_word(input logic [SIZE_W-1:0] s);
      if ($urandom_range(0, 1) == 0) return {25'h0, s};
      return ($urandom & 32'hFFFF_FF80) | {25'h0, s};
   endfunction

   task automatic program_grid(input logic [DATA_W-1:0] ox, input logic [DATA_W-1:0] oy,
                               input logic [DATA_W-1:0] oz, input logic [DATA_W-1:0] inv,
                               input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                               input logic [SIZE_W-1:0] sz, input logic [DATA_W-1:0] far);
      wait_idle();
      csr_put(CSR_ORIGIN_X, ox);
      csr_put(CSR_ORIGIN_Y, oy);
      csr_put(CSR_ORIGIN_Z, oz);
      csr_put(CSR_INV_SPACING, inv);
      csr_put(CSR_SIZE_X, size_word(sx));
      csr_put(CSR_SIZE_Y, size_word(sy));
      csr_put(CSR_SIZE_Z, size_word(sz));
      csr_put(CSR_FAR_VALUE, far);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      n_phases++;
   endtask

   task automatic run_random(input int count);
      int first, settle_at, k, r;
      logic [CH_W-1:0] ch;
      first = n_pushed;
      settle_at = $urandom_range(2, 15);
      k = 0;
      while (n_pushed - first < count) begin
         if (k == settle_at) settle_next = 1'b1;
         k++;
         ch = CH_W'($urandom);
         r = $urandom_range(0, 99);
         if (r < 70)
            push_query(ch, axis_point(cfg_origin[0], cfg_inv, cfg_size[0]),
                       axis_point(cfg_origin[1], cfg_inv, cfg_size[1]),
                       axis_point(cfg_origin[2], cfg_inv, cfg_size[2]));
         else if (r < 82)
            push_write(ch, 15'($urandom), pick_word());
         else
            push_query(ch, pick_word(), pick_word(), pick_word());
      end
   endtask

   function automatic logic [DATA_W-1:0] near_origin();
      return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
   endfunction

   always @(negedge clock) begin : driver
      grid_beat_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !accepted_now) begin
         // hold until the beat is taken
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 1'b0;
      end else if (beat_queue.size() != 0 &&
                   !(beat_queue[0].settle && blend_expect.size() != 0)) begin
         nxt = beat_queue.pop_front();
         req_action <= nxt.act;
         req_channel <= nxt.ch;
         req_cell_index <= nxt.cell_no;
         req_cell_value <= nxt.val;
         req_query_x <= nxt.qx;
         req_query_y <= nxt.qy;
         req_query_z <= nxt.qz;
         start <= 1'b1;
         if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
         end else begin
            if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
            gap_left = next_gap();
         end
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      grid_beat_type seen;
      blend_type want;
      accepted_now <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_strobe) begin
            if (blend_expect.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual value %h outside %b",
                        $time, rsp_value, rsp_outside);
               n_errors++;
            end else begin
               want = blend_expect.pop_front();
               if (rsp_value !== want.value) begin
                  $display("%0t: value mismatch, expected %h actual %h",
                           $time, want.value, rsp_value);
                  n_errors++;
               end
               if (rsp_outside !== want.outside) begin
                  $display("%0t: outside mismatch, expected %b actual %b",
                           $time, want.outside, rsp_outside);
                  n_errors++;
               end
            end
         end
         if (start && !busy) begin
            seen.act = action_type'(req_action);
            seen.ch = req_channel;
            seen.cell_no = req_cell_index;
            seen.val = req_cell_value;
            seen.qx = req_query_x;
            seen.qy = req_query_y;
            seen.qz = req_query_z;
            seen.settle = 1'b0;
            if (seen.act == ACT_WRITE) begin
               field_mem[int'(seen.ch) * MAX_CELLS + int'(seen.cell_no)] = seen.val;
               n_writes++;
            end else begin
               want = predict_blend(seen);
               blend_expect.push_back(want);
               n_queries++;
               if (want.outside) n_outside++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycle_count, blend_expect.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      cfg_origin[0] = '0;
      cfg_origin[1] = '0;
      cfg_origin[2] = '0;
      cfg_inv = 32'h0001_0000;
      cfg_size[0] = 7'd32;
      cfg_size[1] = 7'd32;
      cfg_size[2] = 7'd32;
      cfg_far = 32'h7FFF_FFFF;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      push_write(3'd7, 15'h7FFF, 32'h8000_0000);
      push_write(3'd0, 15'h0000, 32'h7FFF_FFFF);
      push_query(3'd0, 32'h0, 32'h0, 32'h0);
      push_query(3'd0, 32'h0000_8000, 32'h0000_4000, 32'h0000_C000);
      push_query(3'd0, 32'h001F_0000, 32'h0, 32'h0);
      settle_next = 1'b1;
      push_query(3'd5, 32'hFFFF_FFFF, 32'h0, 32'h0);
      push_query(3'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push_query(3'd1, 32'h0, 32'h001E_FFFF, 32'h0);
      push_query(3'd7, 32'h001E_FFFF, 32'h001E_FFFF, 32'h001E_FFFF);
      run_random(PHASE_ITEMS);

      program_grid(32'hFFFC_8000, 32'h0002_4000, 32'h000A_0000, 32'h0002_0000,
                   7'd8, 7'd5, 7'd6, 32'h8000_0000);
      run_random(PHASE_ITEMS);
      program_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                   7'd64, 7'd64, 7'd64, 32'h0);
      run_random(PHASE_ITEMS);
      program_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_4000,
                   7'd2, 7'd2, 7'd2, 32'h1234_5678);
      run_random(PHASE_ITEMS);
      program_grid(near_origin(), near_origin(), near_origin(), 32'h0,
                   7'd3, 7'd64, 7'd2, pick_word());
      run_random(PHASE_ITEMS);
      program_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000,
                   7'd127, 7'd127, 7'd3, $urandom);
      run_random(PHASE_ITEMS);
      program_grid(near_origin(), near_origin(), near_origin(), $urandom,
                   7'd1, 7'd0, 7'd40, $urandom);
      run_random(PHASE_ITEMS);
      program_grid(near_origin(), near_origin(), near_origin(),
                   $urandom_range(32'h0000_8000, 32'h0004_0000),
                   SIZE_W'($urandom_range(2, 64)), SIZE_W'($urandom_range(2, 64)),
                   SIZE_W'($urandom_range(2, 64)), pick_word());
      run_random(PHASE_ITEMS);

      wait_idle();
      $display("covered %0d cell writes and %0d queries (%0d outside the grid)",
               n_writes, n_queries, n_outside);
      $display("over %0d grid settings in %0d cycles, %0d mismatches",
               n_phases, cycle_count, n_errors);
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ grid_trilinear_interpolator_core.f @@
rtl/gti_pkg.sv
rtl/gti_lerp.sv
rtl/grid_trilinear_interpolator_core.sv
bench/tb_top.sv
